// ===== hw/rtl/rim_pkg.sv =====
// ----------------------------------------------------------------------------
// Rollback interval merge package
// Shared widths, defaults and the types passed between the cell chain and
// the merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rim_pkg;

   localparam int SEQ_W           = 64;
   localparam int TXN_W           = 64;
   localparam int MAX_RANGES_DEF  = 64;

   // One stored range of the sorted chain.
   typedef struct packed {
      logic             valid;
      logic [SEQ_W-1:0] seq_start;
      logic [SEQ_W-1:0] seq_end;
   } entry_type;

   // Per-cycle command that every cell of the chain receives.
   typedef struct packed {
      logic ins;   // insert the incoming range in sorted place
      logic pop;   // shift the chain one cell toward the head
   } cell_ctl_type;

   // Batch close information handed to the merge unit.
   typedef struct packed {
      logic             go;
      logic [TXN_W-1:0] txn_id;
      logic             overflow;
   } batch_type;

endpackage : rim_pkg

`default_nettype wire

// ===== hw/rtl/rollback_interval_merge_top.sv =====
// ----------------------------------------------------------------------------
// Rollback interval merge, top level
// Collects the rollback ranges of one transaction in a sorted cell chain and
// emits their union once the batch is closed.
// ----------------------------------------------------------------------------
// Throughput: one range item per cycle while a batch is being collected.
// After the closing item the chain drains through the merge unit at one kept
// range per cycle while the result side does not stall, then the final result
// follows; req_stall is high for that whole drain.
// An empty batch gives a single empty result. Each merged range is registered
// in the result port once a gap or the end of the chain closes it.
// Reset clears the cell valid bits, the range count, the overflow flag, the
// drain state and the output valid; stored range values are not cleared.
`default_nettype none

module rollback_interval_merge_top #(
   parameter int MAX_RANGES = rim_pkg::MAX_RANGES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Range items
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [rim_pkg::TXN_W-1:0] req_txn_id,
   input  wire logic [rim_pkg::SEQ_W-1:0] req_range_start,
   input  wire logic [rim_pkg::SEQ_W-1:0] req_range_end,
   input  wire logic                      req_batch_last,
   // Merged range items
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [rim_pkg::TXN_W-1:0]      rsp_out_txn_id,
   output logic [rim_pkg::SEQ_W-1:0]      rsp_merged_start,
   output logic [rim_pkg::SEQ_W-1:0]      rsp_merged_end,
   output logic                           rsp_run_last,
   output logic                           rsp_set_empty,
   output logic                           rsp_capacity_overflow
);

   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   // The count holds the number of ranges kept in the chain for the batch
   // being collected; it only decides whether the chain is full.
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  overflow_ff, overflow_in;

   logic                  accept;
   logic                  range_ok;
   logic                  full;
   logic                  merge_busy;
   logic                  pop;
   rim_pkg::cell_ctl_type ctl;
   rim_pkg::entry_type    new_range;
   rim_pkg::batch_type    batch;
   rim_pkg::entry_type    cells [MAX_RANGES];
   logic [MAX_RANGES-1:0] after_vec;
   logic [MAX_RANGES-1:0] valid_vec;

   // While the merge unit drains the chain no new item is taken.
   assign req_stall = merge_busy;
   assign accept    = req_valid && !req_stall;
   assign range_ok  = req_range_end > req_range_start;
   assign full      = (count_ff == CNT_W'(MAX_RANGES));

   assign new_range = '{valid: 1'b1, seq_start: req_range_start, seq_end: req_range_end};
   assign ctl       = '{ins: accept && range_ok && !full, pop: pop};

   // A valid range that finds the chain full is dropped and remembered.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff || (accept && range_ok && full);
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (accept && req_batch_last) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   assign batch = '{go:       accept && req_batch_last,
                    txn_id:   req_txn_id,
                    overflow: overflow_ff || (accept && range_ok && full)};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // The sorted chain. Cell 0 holds the smallest range. On insert, the first
   // cell that sorts after the new range takes it and every later cell takes
   // its left neighbor; on drain every cell takes its right neighbor.
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      rim_pkg::entry_type left_entry;
      rim_pkg::entry_type right_entry;
      logic               prev_after;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign prev_after = 1'b0;
      end else begin : g_inner
         assign left_entry = cells[i-1];
         assign prev_after = after_vec[i-1];
      end

      if (i == MAX_RANGES - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cells[i+1];
      end

      rim_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_range   (new_range),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .prev_after  (prev_after),
         .after       (after_vec[i]),
         .entry       (cells[i])
      );

      assign valid_vec[i] = cells[i].valid;
   end

   // The merge unit reads the chain head and owns the result register.
   rim_merge u_merge (
      .clock                 (clock),
      .reset                 (reset),
      .batch                 (batch),
      .head                  (cells[0]),
      .pop                   (pop),
      .busy                  (merge_busy),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_txn_id        (rsp_out_txn_id),
      .rsp_merged_start      (rsp_merged_start),
      .rsp_merged_end        (rsp_merged_end),
      .rsp_run_last          (rsp_run_last),
      .rsp_set_empty         (rsp_set_empty),
      .rsp_capacity_overflow (rsp_capacity_overflow)
   );

   // The kept count never passes the chain length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANGES))
      else $error("kept range count exceeds chain length");

   // Occupied cells always form a prefix of the chain.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + MAX_RANGES'(1))) == '0)
      else $error("cell chain has a hole");

   // Closing a batch starts the drain, which holds off further items.
   a_close_drains: assert property (@(posedge clock) disable iff (reset)
      accept && req_batch_last |=> req_stall)
      else $error("closing item did not start the drain");

   // An empty batch gives exactly one result, which is the last one.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_empty |-> rsp_run_last &&
                                     rsp_merged_start == '0 && rsp_merged_end == '0)
      else $error("empty result is not a lone last result");

endmodule : rollback_interval_merge_top

`default_nettype wire

// ===== hw/rtl/rim_cell.sv =====
// ----------------------------------------------------------------------------
// Rollback interval merge cell
// Holds one range of the sorted chain; takes the new range, the left
// neighbor's range on insert, or the right neighbor's range on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module rim_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rim_pkg::cell_ctl_type ctl,
   input  wire rim_pkg::entry_type    new_range,
   input  wire rim_pkg::entry_type    left_entry,
   input  wire rim_pkg::entry_type    right_entry,
   input  wire logic                  prev_after,
   output logic                       after,
   output rim_pkg::entry_type         entry
);

   logic                      valid_ff;
   logic [rim_pkg::SEQ_W-1:0] start_ff;
   logic [rim_pkg::SEQ_W-1:0] end_ff;
   rim_pkg::entry_type        entry_in;

   assign entry = '{valid: valid_ff, seq_start: start_ff, seq_end: end_ff};

   // An empty cell sorts after everything, so the valid cells stay a prefix.
   always_comb begin
      after = !valid_ff ||
              (start_ff > new_range.seq_start) ||
              ((start_ff == new_range.seq_start) && (end_ff > new_range.seq_end));
   end

   always_comb begin
      entry_in = entry;
      if (ctl.pop) begin
         entry_in = right_entry;
      end else if (ctl.ins && after) begin
         entry_in = prev_after ? left_entry : new_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= entry_in.seq_start;
      end_ff   <= entry_in.seq_end;
   end

endmodule : rim_cell

`default_nettype wire

// ===== hw/rtl/rim_merge.sv =====
// ----------------------------------------------------------------------------
// Rollback interval merge unit
// Drains the sorted chain from its head, one range per cycle unless the result
// port stalls, folds overlapping ranges and drives the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module rim_merge (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rim_pkg::batch_type        batch,
   input  wire rim_pkg::entry_type        head,
   output logic                           pop,
   output logic                           busy,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [rim_pkg::TXN_W-1:0]      rsp_out_txn_id,
   output logic [rim_pkg::SEQ_W-1:0]      rsp_merged_start,
   output logic [rim_pkg::SEQ_W-1:0]      rsp_merged_end,
   output logic                           rsp_run_last,
   output logic                           rsp_set_empty,
   output logic                           rsp_capacity_overflow
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic                      cur_valid_ff, cur_valid_in;
   logic [rim_pkg::SEQ_W-1:0] cur_start_ff, cur_start_in;
   logic [rim_pkg::SEQ_W-1:0] cur_end_ff, cur_end_in;
   logic [rim_pkg::TXN_W-1:0] txn_ff, txn_in;
   logic                      ovf_ff, ovf_in;

   logic                      out_valid_ff, out_valid_in;
   logic [rim_pkg::SEQ_W-1:0] out_start_ff, out_start_in;
   logic [rim_pkg::SEQ_W-1:0] out_end_ff, out_end_in;
   logic [rim_pkg::TXN_W-1:0] out_txn_ff, out_txn_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_empty_ff, out_empty_in;
   logic                      out_ovf_ff, out_ovf_in;

   logic                      out_free;
   logic                      overlap;
   logic                      emit;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign overlap  = cur_valid_ff && (head.seq_start <= cur_end_ff);
   assign busy     = (state_ff == ST_DRAIN);

   always_comb begin
      state_in     = state_ff;
      cur_valid_in = cur_valid_ff;
      cur_start_in = cur_start_ff;
      cur_end_in   = cur_end_ff;
      txn_in       = txn_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_txn_in   = out_txn_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      out_ovf_in   = out_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (batch.go) begin
               state_in     = ST_DRAIN;
               cur_valid_in = 1'b0;
               txn_in       = batch.txn_id;
               ovf_in       = batch.overflow;
            end
         end
         ST_DRAIN: begin
            if (head.valid) begin
               if (!cur_valid_ff) begin
                  pop          = 1'b1;
                  cur_valid_in = 1'b1;
                  cur_start_in = head.seq_start;
                  cur_end_in   = head.seq_end;
               end else if (overlap) begin
                  pop = 1'b1;
                  if (head.seq_end > cur_end_ff) begin
                     cur_end_in = head.seq_end;
                  end
               end else if (out_free) begin
                  // A gap closes the running range.
                  pop          = 1'b1;
                  emit         = 1'b1;
                  out_start_in = cur_start_ff;
                  out_end_in   = cur_end_ff;
                  out_last_in  = 1'b0;
                  out_empty_in = 1'b0;
                  cur_start_in = head.seq_start;
                  cur_end_in   = head.seq_end;
               end
            end else if (out_free) begin
               emit         = 1'b1;
               out_start_in = cur_valid_ff ? cur_start_ff : '0;
               out_end_in   = cur_valid_ff ? cur_end_ff : '0;
               out_last_in  = 1'b1;
               out_empty_in = !cur_valid_ff;
               cur_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
            if (emit) begin
               out_txn_in = txn_ff;
               out_ovf_in = ovf_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = emit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_start_ff <= cur_start_in;
      cur_end_ff   <= cur_end_in;
      txn_ff       <= txn_in;
      ovf_ff       <= ovf_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_txn_ff   <= out_txn_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_out_txn_id        = out_txn_ff;
   assign rsp_merged_start      = out_start_ff;
   assign rsp_merged_end        = out_end_ff;
   assign rsp_run_last          = out_last_ff;
   assign rsp_set_empty         = out_empty_ff;
   assign rsp_capacity_overflow = out_ovf_ff;

endmodule : rim_merge

`default_nettype wire
